// File: sv/lda_collapsed_gibbs_token_sampler_unit_macros.svh
// Assertion helpers shared by the sampler RTL.
`ifndef LDA_COLLAPSED_GIBBS_TOKEN_SAMPLER_UNIT_MACROS_SVH
`define LDA_COLLAPSED_GIBBS_TOKEN_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define LDAGS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ldags: same-cycle check failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define LDAGS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ldags: next-cycle check failed");

`endif

// File: sv/ldags_pkg.sv
`default_nettype none
package ldags_pkg;

    localparam int CNT_W = 17;
    localparam int W_W   = 48;   // Q.16 weight
    localparam int A_W   = 34;   // count*2^16 + prior
    localparam int D_W   = 38;   // total*2^16 + V*beta
    localparam int VB_W  = 37;
    localparam int RED_W = 40;   // index fold compare width

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [1:0] REQ_INIT     = 2'd0;
    localparam logic [1:0] REQ_RESAMPLE = 2'd1;
    localparam logic [1:0] REQ_READ     = 2'd2;
    localparam logic [1:0] REQ_NONE     = 2'd3;

    localparam logic [1:0] CFG_NUM_TOPICS = 2'd0;
    localparam logic [1:0] CFG_VOCAB_SIZE = 2'd1;
    localparam logic [1:0] CFG_ALPHA      = 2'd2;
    localparam logic [1:0] CFG_BETA       = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] word_id;
        logic [9:0]  doc_id;
        logic [15:0] token_id;
        logic [5:0]  given_topic;
        logic [31:0] random_fraction;
    } t_req;

    typedef struct packed {
        logic [5:0]       chosen_topic;
        logic [CNT_W-1:0] word_topic_count;
        logic [CNT_W-1:0] doc_topic_count;
        logic [CNT_W-1:0] topic_total;
        logic             status;
    } t_res;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_REDUCE, ST_TOK_RD, ST_OLD_RD, ST_OLD_WR,
        ST_W_RD, ST_W_MUL, ST_W_DIV, ST_THR0, ST_THR1, ST_SCAN_RD,
        ST_SCAN_CMP, ST_CNT_RD, ST_CNT_WR
    } t_state;

    typedef enum logic [2:0] {
        DV_IDLE, DV_MUL0, DV_MUL1, DV_CHK, DV_LOOP
    } t_div_state;

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + CNT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] cnt_dec(input logic [CNT_W-1:0] c);
        return (c == '0) ? c : c - CNT_W'(1);
    endfunction

endpackage
`default_nettype wire

// File: sv/ldags_muldiv.sv
`default_nettype none
// w = min(floor(a*b/d), 2^48-1), d >= 1; two multiply steps, then one quotient bit a cycle.
module ldags_muldiv import ldags_pkg::*; (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [A_W-1:0] i_a,
    input  wire logic [A_W-1:0] i_b,
    input  wire logic [D_W-1:0] i_d,
    output logic                o_done,
    output logic [W_W-1:0]      o_w
);
    localparam int BL_W = 17;
    localparam int BH_W = A_W - BL_W;
    localparam int PR_W = A_W + BL_W;
    localparam int P_W  = 2 * A_W;
    localparam int H_W  = P_W - W_W;

    t_div_state r_state, n_state;
    logic [A_W-1:0]  r_a;
    logic [BL_W-1:0] r_bl;
    logic [BH_W-1:0] r_bh;
    logic [D_W-1:0]  r_d;
    logic [P_W-1:0]  r_p;
    logic [D_W:0]    r_rem;
    logic [W_W-1:0]  r_q;
    logic [5:0]      r_cnt;
    logic            r_done;

    logic [BL_W-1:0] mul_b;
    logic [PR_W-1:0] prod;
    logic [D_W:0]    rem2;
    logic            q_bit;
    logic            sat;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE: if (i_start) n_state = DV_MUL0;
            DV_MUL0: n_state = DV_MUL1;
            DV_MUL1: n_state = DV_CHK;
            DV_CHK:  n_state = sat ? DV_IDLE : DV_LOOP;
            DV_LOOP: if (r_cnt == '0) n_state = DV_IDLE;
            default: n_state = DV_IDLE;
        endcase
    end

    always_comb begin
        mul_b = (r_state == DV_MUL0) ? r_bl : BL_W'(r_bh);
        prod  = PR_W'(r_a) * PR_W'(mul_b);
        sat   = D_W'(r_p[P_W-1:W_W]) >= r_d;
        rem2  = {r_rem[D_W-1:0], r_p[W_W-1]};
        q_bit = rem2 >= {1'b0, r_d};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == DV_CHK && sat) || (r_state == DV_LOOP && r_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            DV_IDLE: begin
                r_a  <= i_a;
                r_bl <= i_b[BL_W-1:0];
                r_bh <= i_b[A_W-1:BL_W];
                r_d  <= i_d;
            end
            DV_MUL0: r_p <= P_W'(prod);
            DV_MUL1: r_p <= r_p + (P_W'(prod) << BL_W);
            DV_CHK: begin
                r_rem <= (D_W+1)'(r_p[P_W-1:W_W]);
                r_cnt <= 6'(W_W - 1);
                r_q   <= '1;
                if (H_W > 0) r_p <= r_p;
            end
            DV_LOOP: begin
                r_rem <= q_bit ? rem2 - {1'b0, r_d} : rem2;
                r_q   <= {r_q[W_W-2:0], q_bit};
                r_p   <= r_p << 1;
                r_cnt <= r_cnt - 6'd1;
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_done = r_done;
    assign o_w    = r_q;
endmodule
`default_nettype wire

// File: sv/lda_collapsed_gibbs_token_sampler_unit.sv
`default_nettype none
// Init and read: o_res_valid follows the index fold, count read and update; a rejected
// or type-three request strobes once the fold is done. Resample: each topic in use
// costs a count read plus a 48-step quotient in ldags_muldiv (cut short when the
// weight saturates), and the draw scans the prefix store one topic at a time, read
// then compare. One transaction at a time; a new start is taken in the cycle the
// result strobe shows. Reset: defaults reload, then a clearing pass zeroes the count
// stores, busy high. No result stall.
`include "lda_collapsed_gibbs_token_sampler_unit_macros.svh"
module lda_collapsed_gibbs_token_sampler_unit import ldags_pkg::*; #(
    parameter int MAX_TOPICS = 64,
    parameter int MAX_VOCAB  = 4096,
    parameter int MAX_DOCS   = 1024,
    parameter int MAX_TOKENS = 65536
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_req        i_req,
    output logic             o_res_valid,
    output t_res             o_res,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data
);
    // Address widths of the stores
    localparam int TW       = $clog2(MAX_TOPICS);
    localparam int KW       = $clog2(MAX_TOPICS + 1);
    localparam int WT_DEPTH = MAX_VOCAB * MAX_TOPICS;
    localparam int DT_DEPTH = MAX_DOCS * MAX_TOPICS;
    localparam int WT_AW    = $clog2(WT_DEPTH);
    localparam int DT_AW    = $clog2(DT_DEPTH);
    localparam int TOK_AW   = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
    localparam int CLR_N    = (WT_DEPTH > DT_DEPTH) ? WT_DEPTH : DT_DEPTH;
    localparam int CW       = $clog2(CLR_N);
    localparam int SUM_W    = W_W + TW;

    // Configuration registers
    logic [6:0]  r_num_topics;
    logic [12:0] r_vocab;
    logic [23:0] r_alpha;
    logic [23:0] r_beta;
    logic [VB_W-1:0] r_vb;

    // Sequencer and datapath registers
    t_state r_state, n_state;
    logic [CW-1:0]    r_clr;
    t_req             r_req;
    logic [11:0]      r_wid;
    logic [9:0]       r_did;
    logic [15:0]      r_tid;
    logic [3:0]       r_red;
    logic [TW-1:0]    r_t;
    logic [TW-1:0]    r_old;
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_thr;
    t_res             r_res;
    logic             r_res_valid;

    // Memories and their registered read data
    logic [CNT_W-1:0] wt_mem  [WT_DEPTH];
    logic [CNT_W-1:0] dt_mem  [DT_DEPTH];
    logic [CNT_W-1:0] tt_mem  [MAX_TOPICS];
    logic [TW-1:0]    tok_mem [MAX_TOKENS];
    logic [SUM_W-1:0] pre_mem [MAX_TOPICS];
    logic [CNT_W-1:0] r_nw_q, r_nd_q, r_tt_q;
    logic [TW-1:0]    r_tok_q;
    logic [SUM_W-1:0] r_pre_q;

    // Combinational signals
    logic [KW-1:0]    k_eff;
    logic [TW-1:0]    k_last;
    logic             given_bad;
    logic             old_ok;
    logic [RED_W-1:0] red_w, red_d, red_t;
    logic [TW-1:0]    rd_topic, wr_topic;
    logic             cnt_we, tok_we, pre_we;
    logic [WT_AW-1:0] wt_raddr, wt_waddr;
    logic [DT_AW-1:0] dt_raddr, dt_waddr;
    logic [TW-1:0]    tt_raddr, tt_waddr;
    logic [CNT_W-1:0] nw_wdata, nd_wdata, tt_wdata;
    logic             wt_we, dt_we, tt_we;
    logic [A_W-1:0]   op_a, op_b;
    logic [D_W-1:0]   op_d, den;
    logic             div_start, div_done;
    logic [W_W-1:0]   div_w;
    logic [SUM_W-1:0] n_sum;
    logic [63:0]      thr_lo;
    logic [SUM_W-1:0] thr_hi;
    logic             res_counts_zero;

    // K in use: zero acts as one, anything above MAX_TOPICS is clipped
    always_comb begin
        if (r_num_topics == '0)
            k_eff = KW'(1);
        else if (32'(r_num_topics) > MAX_TOPICS)
            k_eff = KW'(MAX_TOPICS);
        else
            k_eff = KW'(r_num_topics);
        k_last    = TW'(k_eff - KW'(1));
        given_bad = 32'(r_req.given_topic) >= 32'(k_eff);
        old_ok    = 32'(r_tok_q) < 32'(k_eff);
        red_w     = RED_W'(MAX_VOCAB) << r_red;
        red_d     = RED_W'(MAX_DOCS) << r_red;
        red_t     = RED_W'(MAX_TOKENS) << r_red;
    end

    // Config port: always ready, defaults on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_topics <= 7'd16;
            r_vocab      <= 13'd4096;
            r_alpha      <= 24'd204800;
            r_beta       <= 24'd6554;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_TOPICS: r_num_topics <= i_cfg_data[6:0];
                CFG_VOCAB_SIZE: r_vocab      <= i_cfg_data[12:0];
                CFG_ALPHA:      r_alpha      <= i_cfg_data;
                CFG_BETA:       r_beta       <= i_cfg_data;
                default:        r_beta       <= r_beta;
            endcase
        end
    end

    // V*beta, registered; user keeps config steady during a transaction; not enforced
    always_ff @(posedge i_clk) begin
        r_vb <= VB_W'(r_vocab) * VB_W'(r_beta);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr == CW'(CLR_N - 1)) n_state = ST_IDLE;
            ST_IDLE:   if (start) n_state = ST_REDUCE;
            ST_REDUCE: begin
                if (r_red == '0) begin
                    unique case (r_req.req_type) inside
                        REQ_RESAMPLE:       n_state = ST_TOK_RD;
                        REQ_INIT, REQ_READ: n_state = given_bad ? ST_IDLE : ST_CNT_RD;
                        default:            n_state = ST_IDLE;
                    endcase
                end
            end
            ST_TOK_RD:   n_state = ST_OLD_RD;
            ST_OLD_RD:   n_state = old_ok ? ST_OLD_WR : ST_W_RD;
            ST_OLD_WR:   n_state = ST_W_RD;
            ST_W_RD:     n_state = ST_W_MUL;
            ST_W_MUL:    n_state = ST_W_DIV;
            ST_W_DIV:    if (div_done) n_state = (r_t == k_last) ? ST_THR0 : ST_W_RD;
            ST_THR0:     n_state = ST_THR1;
            ST_THR1:     n_state = ST_SCAN_RD;
            ST_SCAN_RD:  n_state = ST_SCAN_CMP;
            ST_SCAN_CMP: begin
                if (r_pre_q > r_thr || r_t == k_last) n_state = ST_CNT_RD;
                else                                  n_state = ST_SCAN_RD;
            end
            ST_CNT_RD:   n_state = ST_CNT_WR;
            ST_CNT_WR:   n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory ports and divider start
    always_comb begin
        busy      = (r_state != ST_IDLE);
        rd_topic  = (r_state == ST_OLD_RD) ? r_tok_q : r_t;
        wr_topic  = (r_state == ST_OLD_WR) ? r_old : r_t;
        cnt_we    = (r_state == ST_OLD_WR) ||
                    (r_state == ST_CNT_WR && r_req.req_type != REQ_READ);
        tok_we    = (r_state == ST_CNT_WR && r_req.req_type != REQ_READ);
        pre_we    = (r_state == ST_W_DIV && div_done);
        div_start = (r_state == ST_W_MUL);

        wt_raddr = WT_AW'(r_wid) * WT_AW'(MAX_TOPICS) + WT_AW'(rd_topic);
        dt_raddr = DT_AW'(r_did) * DT_AW'(MAX_TOPICS) + DT_AW'(rd_topic);
        tt_raddr = rd_topic;

        if (r_state == ST_CLEAR) begin
            wt_waddr = r_clr[WT_AW-1:0];
            dt_waddr = r_clr[DT_AW-1:0];
            tt_waddr = r_clr[TW-1:0];
            nw_wdata = '0;
            nd_wdata = '0;
            tt_wdata = '0;
            wt_we    = 32'(r_clr) < WT_DEPTH;
            dt_we    = 32'(r_clr) < DT_DEPTH;
            tt_we    = 32'(r_clr) < MAX_TOPICS;
        end else begin
            wt_waddr = WT_AW'(r_wid) * WT_AW'(MAX_TOPICS) + WT_AW'(wr_topic);
            dt_waddr = DT_AW'(r_did) * DT_AW'(MAX_TOPICS) + DT_AW'(wr_topic);
            tt_waddr = wr_topic;
            if (r_state == ST_OLD_WR) begin
                nw_wdata = cnt_dec(r_nw_q);
                nd_wdata = cnt_dec(r_nd_q);
                tt_wdata = cnt_dec(r_tt_q);
            end else begin
                nw_wdata = cnt_inc(r_nw_q);
                nd_wdata = cnt_inc(r_nd_q);
                tt_wdata = cnt_inc(r_tt_q);
            end
            wt_we = cnt_we;
            dt_we = cnt_we;
            tt_we = cnt_we;
        end

        // Weight operands in Q.16; a zero denominator counts as one
        op_a  = (A_W'(r_nw_q) << 16) + A_W'(r_beta);
        op_b  = (A_W'(r_nd_q) << 16) + A_W'(r_alpha);
        den   = (D_W'(r_tt_q) << 16) + D_W'(r_vb);
        op_d  = (den == '0) ? D_W'(1) : den;
        n_sum = r_sum + SUM_W'(div_w);

        // Threshold floor(S*r/2^32) in two multiplies
        thr_lo = 64'(r_sum[31:0]) * 64'(r_req.random_fraction);
        thr_hi = SUM_W'(r_sum[SUM_W-1:32]) * SUM_W'(r_req.random_fraction);
    end

    ldags_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_d     (op_d),
        .o_done  (div_done),
        .o_w     (div_w)
    );

    // Count stores, token store and prefix store
    always_ff @(posedge i_clk) begin
        if (wt_we) wt_mem[wt_waddr] <= nw_wdata;
        r_nw_q <= wt_mem[wt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (dt_we) dt_mem[dt_waddr] <= nd_wdata;
        r_nd_q <= dt_mem[dt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tt_we) tt_mem[tt_waddr] <= tt_wdata;
        r_tt_q <= tt_mem[tt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (tok_we) tok_mem[TOK_AW'(r_tid)] <= r_t;
        r_tok_q <= tok_mem[TOK_AW'(r_tid)];
    end

    always_ff @(posedge i_clk) begin
        if (pre_we) pre_mem[r_t] <= n_sum;
        r_pre_q <= pre_mem[r_t];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= r_clr + CW'(1);
            r_res_valid <= (r_state == ST_CNT_WR) ||
                           (r_state == ST_REDUCE && r_red == '0 &&
                            (r_req.req_type == REQ_NONE ||
                             (r_req.req_type != REQ_RESAMPLE && given_bad)));
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_req <= i_req;
                r_wid <= i_req.word_id;
                r_did <= i_req.doc_id;
                r_tid <= i_req.token_id;
                r_red <= 4'hF;
            end
            ST_REDUCE: begin
                // fold each index below its store depth, one shifted depth a cycle
                if (RED_W'(r_wid) >= red_w) r_wid <= r_wid - 12'(red_w);
                if (RED_W'(r_did) >= red_d) r_did <= r_did - 10'(red_d);
                if (RED_W'(r_tid) >= red_t) r_tid <= r_tid - 16'(red_t);
                r_red <= r_red - 4'd1;
                if (r_red == '0) begin
                    r_t <= TW'(r_req.given_topic);
                    // rejected: topic echoed, counts zero; type three: all zero
                    if (r_req.req_type == REQ_NONE)
                        r_res <= '0;
                    else
                        r_res <= t_res'{r_req.given_topic, CNT_W'(0), CNT_W'(0),
                                        CNT_W'(0), 1'b1};
                end
            end
            ST_TOK_RD: begin
                r_sum <= '0;
                r_t   <= '0;
            end
            ST_OLD_RD: r_old <= r_tok_q;
            ST_W_DIV: begin
                if (div_done) begin
                    r_sum <= n_sum;
                    if (r_t != k_last) r_t <= r_t + TW'(1);
                end
            end
            ST_THR0: r_thr <= SUM_W'(thr_lo[63:32]);
            ST_THR1: begin
                r_thr <= r_thr + thr_hi;
                r_t   <= '0;
            end
            ST_SCAN_CMP: begin
                if (!(r_pre_q > r_thr || r_t == k_last)) r_t <= r_t + TW'(1);
            end
            ST_CNT_WR: begin
                if (r_req.req_type == REQ_READ)
                    r_res <= t_res'{6'(r_t), r_nw_q, r_nd_q, r_tt_q, 1'b0};
                else
                    r_res <= t_res'{6'(r_t), nw_wdata, nd_wdata, tt_wdata, 1'b0};
            end
            default: r_old <= r_old;
        endcase
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;
    assign o_cfg_ready = 1'b1;

    assign res_counts_zero = (r_res.word_topic_count == '0) &&
                             (r_res.doc_topic_count == '0) &&
                             (r_res.topic_total == '0);

    // Checks
    `LDAGS_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `LDAGS_ASSERT_IMP(a_res_idle, r_res_valid, r_state == ST_IDLE)
    `LDAGS_ASSERT_IMP(a_reject_zero, r_res_valid && r_res.status, res_counts_zero)
    `LDAGS_ASSERT_IMP(a_no_res_clear, r_state == ST_CLEAR, !r_res_valid)
endmodule
`default_nettype wire

// File: sim/lda_collapsed_gibbs_token_sampler_unit_test.sv
`default_nettype none
module lda_collapsed_gibbs_token_sampler_unit_test import ldags_pkg::*;;

    // Idle cycles before the watchdog gives up: several times the count-store
    // clearing pass after reset, far above a K=64 resample.
    localparam int IDLE_LIMIT = 1200000;
    localparam logic [63:0] WEIGHT_MAX = 64'hFFFF_FFFF_FFFF;

    // Shadow of the sampler: count stores, token topics and registers.
    // Expected results are computed on each accepted transaction.
    class topic_scoreboard;
        logic [16:0] word_cnt [0:262143];
        logic [16:0] doc_cnt [0:65535];
        logic [16:0] tot_cnt [0:63];
        logic [5:0]  tok_topic [0:65535];
        bit          tok_seen [0:65535];
        int unsigned seen_toks [$];
        t_res        awaited [$];
        logic [6:0]  n_topics;
        logic [12:0] vocab;
        logic [23:0] alpha, beta;
        int          mismatches;

        function new();
            foreach (word_cnt[i]) word_cnt[i] = '0;
            foreach (doc_cnt[i]) doc_cnt[i] = '0;
            foreach (tot_cnt[i]) tot_cnt[i] = '0;
            foreach (tok_seen[i]) tok_seen[i] = 0;
            n_topics = 7'd16;
            vocab = 13'd4096;
            alpha = 24'd204800;
            beta = 24'd6554;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [23:0] val);
            case (idx)
                CFG_NUM_TOPICS: n_topics = val[6:0];
                CFG_VOCAB_SIZE: vocab = val[12:0];
                CFG_ALPHA:      alpha = val;
                CFG_BETA:       beta = val;
            endcase
        endfunction

        function int unsigned topics_in_use();
            if (n_topics == 0) return 1;
            if (n_topics > 64) return 64;
            return 32'(n_topics);
        endfunction

        // Saturating count bump / drop.
        function logic [16:0] up(logic [16:0] c);
            return (c == 17'h1FFFF) ? c : c + 17'd1;
        endfunction

        function logic [16:0] down(logic [16:0] c);
            return (c == 0) ? c : c - 17'd1;
        endfunction

        function void count_in(int unsigned wb, int unsigned db, int unsigned t);
            word_cnt[wb + t] = up(word_cnt[wb + t]);
            doc_cnt[db + t] = up(doc_cnt[db + t]);
            tot_cnt[t] = up(tot_cnt[t]);
        endfunction

        function void note_req(t_req r);
            t_res        o;
            int unsigned k, t, old, wb, db;
            logic [63:0] sum, thr, a, b, den, vb;
            logic [127:0] q;
            logic [63:0] prefix [0:63];
            o = '0;
            k = topics_in_use();
            wb = 32'(r.word_id) * 64;
            db = 32'(r.doc_id) * 64;
            t = 0;
            if (r.req_type == REQ_NONE) begin
                awaited = {awaited, o};
                return;
            end
            if (r.req_type != REQ_RESAMPLE) begin
                if (r.given_topic >= k) begin
                    o.chosen_topic = r.given_topic;
                    o.status = 1'b1;
                    awaited = {awaited, o};
                    return;
                end
                t = 32'(r.given_topic);
                if (r.req_type == REQ_INIT) begin
                    tok_topic[r.token_id] = 6'(t);
                    if (!tok_seen[r.token_id]) seen_toks = {seen_toks, 32'(r.token_id)};
                    tok_seen[r.token_id] = 1;
                    count_in(wb, db, t);
                end
            end else begin
                old = 32'(tok_topic[r.token_id]);
                if (old < k) begin
                    word_cnt[wb + old] = down(word_cnt[wb + old]);
                    doc_cnt[db + old] = down(doc_cnt[db + old]);
                    tot_cnt[old] = down(tot_cnt[old]);
                end
                vb = 64'(vocab) * 64'(beta);
                sum = 0;
                for (int i = 0; i < k; i++) begin
                    a = {word_cnt[wb + i], 16'h0} + 64'(beta);
                    b = {doc_cnt[db + i], 16'h0} + 64'(alpha);
                    den = {tot_cnt[i], 16'h0} + vb;
                    if (den == 0) den = 1;
                    q = (128'(a) * 128'(b)) / 128'(den);
                    if (q > 128'(WEIGHT_MAX)) q = 128'(WEIGHT_MAX);
                    sum = sum + q[63:0];
                    prefix[i] = sum;
                end
                q = (128'(sum) * 128'(r.random_fraction)) >> 32;
                thr = q[63:0];
                // first prefix strictly above the threshold, else the last topic
                t = k - 1;
                for (int i = k - 1; i >= 0; i--)
                    if (prefix[i] > thr) t = i;
                count_in(wb, db, t);
                tok_topic[r.token_id] = 6'(t);
            end
            o.chosen_topic = 6'(t);
            o.word_topic_count = word_cnt[wb + t];
            o.doc_topic_count = doc_cnt[db + t];
            o.topic_total = tot_cnt[t];
            awaited = {awaited, o};
        endfunction

        function void check_res(t_res got);
            t_res exp_r;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: topic %0d wc %0d dc %0d tot %0d st %0b",
                             got.chosen_topic, got.word_topic_count, got.doc_topic_count,
                             got.topic_total, got.status);
                return;
            end
            exp_r = awaited.pop_front();
            if (got !== exp_r) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch: exp topic %0d wc %0d dc %0d tot %0d st %0b",
                             exp_r.chosen_topic, exp_r.word_topic_count,
                             exp_r.doc_topic_count, exp_r.topic_total, exp_r.status);
                    $display("                 act topic %0d wc %0d dc %0d tot %0d st %0b",
                             got.chosen_topic, got.word_topic_count, got.doc_topic_count,
                             got.topic_total, got.status);
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_req        i_req = '0;
    logic        o_res_valid;
    t_res        o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    topic_scoreboard sb = new();
    int unsigned idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    lda_collapsed_gibbs_token_sampler_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_res_valid(o_res_valid), .o_res(o_res), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Results cannot be stalled: check every strobe. Strobes also feed the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid)
            sb.check_res(o_res);
        if (!i_rst_n || o_res_valid || (start && !busy) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // One request transaction; start is left high so a back-to-back item needs
    // no lowering in between.
    task automatic send_req(t_req r);
        int unsigned gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) gap = 0;   // runs with no idling
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sb.note_req(r);
    endtask

    // Valid stays high across a run of writes; set_regs lowers it afterwards.
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // Let the block drain before touching the registers.
    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [6:0] k, logic [12:0] v, logic [23:0] a, logic [23:0] b);
        drain();
        write_reg(CFG_NUM_TOPICS, 24'(k));
        write_reg(CFG_VOCAB_SIZE, 24'(v));
        write_reg(CFG_ALPHA, a);
        write_reg(CFG_BETA, b);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_req mk(logic [1:0] rt, int unsigned w, int unsigned d,
                                int unsigned tok, int unsigned g, logic [31:0] rf);
        t_req r;
        r.req_type = rt;
        r.word_id = 12'(w);
        r.doc_id = 10'(d);
        r.token_id = 16'(tok);
        r.given_topic = 6'(g);
        r.random_fraction = rf;
        return r;
    endfunction

    // Mostly well-formed traffic over a small corpus so counts build up;
    // resamples only name tokens already placed.
    function automatic t_req rand_req();
        t_req        r;
        int unsigned k, sel;
        k = sb.topics_in_use();
        sel = $urandom_range(0, 99);
        r.word_id = 12'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 15));
        r.doc_id = 10'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7));
        r.token_id = 16'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 127));
        r.given_topic = 6'(($urandom_range(0, 7) == 0) ? $urandom
                                                       : $urandom_range(0, k - 1));
        case ($urandom_range(0, 9))
            0: r.random_fraction = '0;
            1: r.random_fraction = '1;
            default: r.random_fraction = $urandom;
        endcase
        if (sel < 35 || sb.seen_toks.size() == 0) begin
            r.req_type = REQ_INIT;
        end else if (sel < 80) begin
            r.req_type = REQ_RESAMPLE;
            r.token_id = 16'(sb.seen_toks[$urandom_range(0, sb.seen_toks.size() - 1)]);
        end else if (sel < 95) begin
            r.req_type = REQ_READ;
        end else begin
            r = t_req'({REQ_NONE, 76'({$urandom, $urandom, $urandom})});
        end
        return r;
    endfunction

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers, K=16: corners of every field, each request type.
        send_req(mk(REQ_INIT, 0, 0, 0, 0, 32'h0));
        send_req(mk(REQ_INIT, 4095, 1023, 65535, 15, 32'hFFFF_FFFF));
        send_req(mk(REQ_INIT, 4095, 1023, 100, 15, 32'h0));
        send_req(mk(REQ_INIT, 1, 1, 101, 63, 32'h0));          // topic not below K
        send_req(mk(REQ_READ, 4095, 1023, 0, 15, 32'h0));
        send_req(mk(REQ_READ, 0, 0, 0, 40, 32'h0));            // rejected read
        send_req(mk(REQ_NONE, 4095, 1023, 65535, 63, 32'hFFFF_FFFF));
        send_req(mk(REQ_RESAMPLE, 0, 0, 0, 0, 32'h0));
        send_req(mk(REQ_RESAMPLE, 4095, 1023, 65535, 0, 32'hFFFF_FFFF));
        send_req(mk(REQ_RESAMPLE, 4095, 1023, 100, 0, 32'h8000_0000));

        // K register zero behaves as one topic.
        set_regs(7'd0, 13'd1, 24'd0, 24'd1);
        send_req(mk(REQ_INIT, 5, 5, 200, 0, 32'h0));
        send_req(mk(REQ_INIT, 5, 5, 201, 1, 32'h0));
        send_req(mk(REQ_RESAMPLE, 5, 5, 200, 0, 32'hFFFF_FFFF));
        // Old topic 15 of token 65535 is now out of range: removal skipped.
        send_req(mk(REQ_RESAMPLE, 4095, 1023, 65535, 0, 32'h1234_5678));

        // K above the limit, huge priors, V=0: zero denominators, weights near full scale.
        set_regs(7'd127, 13'd0, 24'hFF_FFFF, 24'hFF_FFFF);
        send_req(mk(REQ_INIT, 7, 3, 300, 63, 32'h0));
        send_req(mk(REQ_RESAMPLE, 7, 3, 300, 0, 32'hFFFF_FFFF));
        send_req(mk(REQ_RESAMPLE, 7, 3, 300, 0, 32'h0));

        // All priors zero: zero denominators and an all-zero weight sum.
        set_regs(7'd4, 13'd8191, 24'd0, 24'd0);
        send_req(mk(REQ_INIT, 9, 9, 400, 3, 32'h0));
        send_req(mk(REQ_RESAMPLE, 9, 9, 400, 0, 32'h4000_0000));
        send_req(mk(REQ_RESAMPLE, 11, 11, 400, 0, 32'hFFFF_FFFF));
        send_req(mk(REQ_READ, 11, 11, 0, 3, 32'h0));

        // Random phases, mostly small K to keep resamples short; each phase
        // ends with a full drain.
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7)
                set_regs(7'd64, 13'd4096, 24'd204800, 24'd6554);
            else
                set_regs(7'($urandom_range(2, 8)), 13'($urandom),
                         ($urandom_range(0, 2) == 0) ? 24'($urandom)
                                                     : 24'($urandom_range(0, 400000)),
                         ($urandom_range(0, 2) == 0) ? 24'($urandom)
                                                     : 24'($urandom_range(0, 20000)));
            repeat ((ph == 7) ? 20 : 145) send_req(rand_req());
        end

        start <= 1'b0;
        do @(posedge i_clk); while (sb.awaited.size() != 0);
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire
